/* rtl/boa_pkg.sv */
// Shared types, codes and widths for the bitmap object allocator.
`timescale 1ns / 1ps

package boa_pkg;

    localparam int WORD_BITS   = 64;
    localparam int BIT_W       = 6;
    localparam int SIZE_W      = 17;
    localparam int COUNT_W     = 13;
    localparam int OFFSET_W    = 28;
    localparam int INDEX_W     = 12;
    localparam int WCNT_W      = 8;
    localparam int DIV_CNT_W   = 5;

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 17'd64;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_NOTALLOC = 2'd3;

    localparam logic CFG_OBJ_SIZE  = 1'b0;
    localparam logic CFG_OBJ_COUNT = 1'b1;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic                start;
        logic [OFFSET_W-1:0] dividend;
        logic [SIZE_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [OFFSET_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* rtl/boa_divider.sv */
// Restoring divider, one quotient bit per cycle, for offset-to-index conversion.
`timescale 1ns / 1ps

module boa_divider
    import boa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [OFFSET_W-1:0]  r_quo, n_quo;
    logic [SIZE_W-1:0]    r_rem, n_rem;
    logic [SIZE_W-1:0]    r_dsr, n_dsr;
    logic [SIZE_W:0]      rem_sh;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        rem_sh = {r_rem, r_quo[OFFSET_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dsr  = i_req.divisor;
        end else if (r_busy) begin
            // shift one dividend bit in, subtract where it fits
            if (rem_sh >= {1'b0, r_dsr}) begin
                n_rem = SIZE_W'(rem_sh - {1'b0, r_dsr});
                n_quo = {r_quo[OFFSET_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[SIZE_W-1:0];
                n_quo = {r_quo[OFFSET_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(OFFSET_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

/* rtl/boa_bitmap.sv */
// Usage bitmap memory with registered read and a clearing sweep after reset.
`timescale 1ns / 1ps

module boa_bitmap
    import boa_pkg::*;
#(
    parameter int WORDS  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_word             i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_word             o_rd_data,
    output logic              o_ready
);

    t_word             mem [WORDS];
    t_word             r_rd_data;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(WORDS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_clearing;

endmodule

/* rtl/bitmap_object_allocator_core.sv */
// Top level of the bitmap object allocator: sequencer, registers and stream ports.
`timescale 1ns / 1ps
// Allocate: one bitmap word scanned per cycle (up to ceil(pool/64) words), then S_MUL and
//   S_DONE; the scan loop around the registered bitmap read port sets this rate.
// Free: the bit-serial divider (S_DIV), then lookup and update (S_FCHK) and the offset
//   multiply (S_MUL). One request is in flight at a time.
// Reset (synchronous, active low) clears the count and restores the registers, then
//   the bitmap clearing sweep clears all MAX_OBJECTS/64 words before input is accepted.

module bitmap_object_allocator_core
    import boa_pkg::*;
#(
    parameter int MAX_OBJECTS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_addr,
    input  logic [16:0] i_cfg_wr_data,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [27:0] offset
    input  logic [0:0]  i_s_tuser,   // [0] opcode
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // [11:0] index, [39:12] byte_offset, [52:40] used_count
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    localparam int WORDS  = MAX_OBJECTS / WORD_BITS;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    // largest pool the 13-bit count can describe, capped by the bitmap size
    localparam logic [COUNT_W-1:0] POOL_CAP =
        COUNT_W'((MAX_OBJECTS < 8191) ? MAX_OBJECTS : 8191);
    localparam logic [WCNT_W-1:0] LIM_CAP = WCNT_W'((WORDS < 128) ? WORDS : 128);
    // objects that whole bitmap words can track; indices past this are never allocated
    localparam logic [OFFSET_W-1:0] WORD_CAP = OFFSET_W'(WORDS * WORD_BITS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_AEVAL = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_FCHK  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // configuration
    logic [SIZE_W-1:0]  r_obj_size;
    logic [COUNT_W-1:0] r_obj_count;

    // sequencer state
    logic [2:0]          r_state, n_state;
    logic [WCNT_W-1:0]   r_word, n_word;
    logic [COUNT_W-1:0]  r_idx, n_idx;
    logic [1:0]          r_status, n_status;
    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic [OFFSET_W-1:0] r_boff, n_boff;
    logic [COUNT_W-1:0]  r_used, n_used;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_out_status;
    logic [INDEX_W-1:0]  r_out_index;
    logic [OFFSET_W-1:0] r_out_boff;
    logic [COUNT_W-1:0]  r_out_used;
    logic                out_load;

    // bitmap port
    logic              bm_wr_en;
    logic [ADDR_W-1:0] bm_wr_addr;
    t_word             bm_wr_data;
    logic [ADDR_W-1:0] bm_rd_addr;
    t_word             bm_rd_data;
    logic              bm_ready;

    // divider port
    t_div_req div_req;
    t_div_rsp div_rsp;

    // scan datapath
    logic [COUNT_W-1:0] pool_n;
    logic [WCNT_W-1:0]  lim_raw;
    logic [WCNT_W-1:0]  scan_lim;
    logic [COUNT_W-1:0] left;
    t_word              valid_mask;
    t_word              free_bits;
    t_word              low_bit;
    logic [BIT_W-1:0]   low_pos;
    logic [WCNT_W-1:0]  word_inc;
    logic               in_xfer;
    logic [COUNT_W+SIZE_W-1:0] prod;

    boa_bitmap #(
        .WORDS  (WORDS),
        .ADDR_W (ADDR_W)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (bm_wr_en),
        .i_wr_addr (bm_wr_addr),
        .i_wr_data (bm_wr_data),
        .i_rd_addr (bm_rd_addr),
        .o_rd_data (bm_rd_data),
        .o_ready   (bm_ready)
    );

    boa_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj_size  <= SIZE_RESET;
            r_obj_count <= COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_OBJ_SIZE:  r_obj_size  <= i_cfg_wr_data;
                CFG_OBJ_COUNT: r_obj_count <= i_cfg_wr_data[COUNT_W-1:0];
                default:       r_obj_size  <= r_obj_size;
            endcase
        end
    end

    // pool size and number of words worth scanning
    assign pool_n   = (r_obj_count > POOL_CAP) ? POOL_CAP : r_obj_count;
    assign lim_raw  = WCNT_W'(({1'b0, pool_n} + 14'd63) >> BIT_W);
    assign scan_lim = (lim_raw > LIM_CAP) ? LIM_CAP : lim_raw;
    assign word_inc = r_word + 1'b1;

    // free bits of the word being looked at, lowest one isolated
    assign left       = pool_n - COUNT_W'({r_word, {BIT_W{1'b0}}});
    assign valid_mask = (left >= COUNT_W'(WORD_BITS)) ? '1
                        : ((t_word'(1) << left[BIT_W-1:0]) - t_word'(1));
    assign free_bits  = ~bm_rd_data & valid_mask;
    assign low_bit    = free_bits & (~free_bits + t_word'(1));

    always_comb begin
        low_pos = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (low_bit[b]) begin
                low_pos = low_pos | BIT_W'(b);
            end
        end
    end

    assign prod       = r_idx * r_obj_size;
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE) && bm_ready;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state    = r_state;
        n_word     = r_word;
        n_idx      = r_idx;
        n_status   = r_status;
        n_offset   = r_offset;
        n_boff     = r_boff;
        n_used     = r_used;
        bm_wr_en   = 1'b0;
        bm_wr_addr = ADDR_W'(r_idx[COUNT_W-1:BIT_W]);
        bm_wr_data = bm_rd_data;
        bm_rd_addr = '0;
        div_req.start    = 1'b0;
        div_req.dividend = r_offset;
        div_req.divisor  = r_obj_size;

        case (r_state)
            S_IDLE: begin
                // word zero is read on acceptance, ready for the first compare
                if (in_xfer) begin
                    n_offset = i_s_tdata[OFFSET_W-1:0];
                    n_idx    = '0;
                    n_boff   = '0;
                    n_word   = '0;
                    if (i_s_tuser[0] == OP_ALLOC) begin
                        if (scan_lim == '0) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_AEVAL;
                        end
                    end else if (r_obj_size == '0) begin
                        n_status = ST_RANGE;
                        n_state  = S_DONE;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = i_s_tdata[OFFSET_W-1:0];
                        n_state          = S_DIV;
                    end
                end
            end
            S_AEVAL: begin
                bm_rd_addr = ADDR_W'(word_inc);
                if (free_bits != '0) begin
                    // claim the lowest free object of this word
                    bm_wr_en   = 1'b1;
                    bm_wr_addr = ADDR_W'(r_word);
                    bm_wr_data = bm_rd_data | low_bit;
                    n_idx      = COUNT_W'({r_word, low_pos});
                    n_used     = r_used + 1'b1;
                    n_state    = S_MUL;
                end else if (word_inc >= scan_lim) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_word = word_inc;
                end
            end
            S_DIV: begin
                bm_rd_addr = ADDR_W'(div_rsp.quotient[COUNT_W-1:BIT_W]);
                if (div_rsp.done) begin
                    if (div_rsp.quotient >= OFFSET_W'(pool_n)) begin
                        n_status = ST_RANGE;
                        n_state  = S_DONE;
                    end else if (div_rsp.quotient >= WORD_CAP) begin
                        // past the last bitmap word: never allocated
                        n_status = ST_NOTALLOC;
                        n_state  = S_DONE;
                    end else begin
                        n_idx   = div_rsp.quotient[COUNT_W-1:0];
                        n_state = S_FCHK;
                    end
                end
            end
            S_FCHK: begin
                if (!bm_rd_data[r_idx[BIT_W-1:0]]) begin
                    n_idx    = '0;
                    n_status = ST_NOTALLOC;
                    n_state  = S_DONE;
                end else begin
                    bm_wr_en   = 1'b1;
                    bm_wr_data = bm_rd_data & ~(t_word'(1) << r_idx[BIT_W-1:0]);
                    if (r_used != '0) begin
                        n_used = r_used - 1'b1;
                    end
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_boff   = prod[OFFSET_W-1:0];
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
        r_word   <= n_word;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_offset <= n_offset;
        r_boff   <= n_boff;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_index  <= r_idx[INDEX_W-1:0];
            r_out_boff   <= r_boff;
            r_out_used   <= r_used;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {3'b000, r_out_used, r_out_boff, r_out_index};

endmodule

/* tb/sv/bitmap_object_allocator_core_test.sv */
// Self-checking testbench for the bitmap object allocator core.
`timescale 1ns / 1ps

module bitmap_object_allocator_core_test;
    import boa_pkg::*;

    localparam int POOL_MAX      = 4096;
    localparam int POOL_WORDS    = POOL_MAX / WORD_BITS;
    // Longest request: a 64-word scan plus overhead, so this covers any tail.
    localparam int SETTLE_CYCLES = 80;
    localparam logic [OFFSET_W-1:0] OFFSET_TOP = '1;

    // One outcome as the result stream carries it.
    typedef struct {
        logic [1:0]          status;
        logic [INDEX_W-1:0]  index;
        logic [OFFSET_W-1:0] byte_offset;
        logic [COUNT_W-1:0]  used_count;
    } t_alloc_outcome;

    // Mirror of the pool: usage words, live count and registers, plus the
    // outcomes that are still on their way out of the block.
    class allocator_mirror;
        bit [WORD_BITS-1:0] usage_words [POOL_WORDS];
        int unsigned        in_use;
        logic [SIZE_W-1:0]  object_size;
        logic [COUNT_W-1:0] object_count;
        t_alloc_outcome     awaited_outcomes [$];
        int unsigned        failures;

        function new();
            foreach (usage_words[w]) usage_words[w] = '0;
            in_use       = 0;
            object_size  = SIZE_RESET;
            object_count = COUNT_RESET;
            failures     = 0;
        endfunction

        function void write_register(logic addr, logic [SIZE_W-1:0] value);
            if (addr == CFG_OBJ_SIZE) object_size = value;
            else object_count = value[COUNT_W-1:0];
        endfunction

        // Counts beyond the pool capacity saturate.
        function int unsigned pool_objects();
            return (object_count > POOL_MAX) ? POOL_MAX : object_count;
        endfunction

        function logic [OFFSET_W-1:0] scaled(int unsigned idx);
            logic [63:0] prod;
            prod = 64'(idx) * 64'(object_size);
            return prod[OFFSET_W-1:0];
        endfunction

        // Work out the outcome of an accepted request and queue it.
        function void note_request(logic op, logic [OFFSET_W-1:0] offset);
            t_alloc_outcome      res;
            int unsigned         n, words, w, b, idx, left;
            bit [WORD_BITS-1:0]  open_bits;
            logic [OFFSET_W-1:0] quot;
            n = pool_objects();
            res.status      = ST_FULL;
            res.index       = '0;
            res.byte_offset = '0;
            if (op == OP_ALLOC) begin
                words = (n + WORD_BITS - 1) / WORD_BITS;
                for (w = 0; w < words; w++) begin
                    left      = n - w * WORD_BITS;
                    open_bits = ~usage_words[w];
                    if (left < WORD_BITS) open_bits &= (64'd1 << left) - 64'd1;
                    if (open_bits != 0 && res.status != ST_OK) begin
                        b = 0;
                        while (!open_bits[b]) b++;
                        idx = w * WORD_BITS + b;
                        usage_words[w][b] = 1'b1;
                        in_use++;
                        res.status      = ST_OK;
                        res.index       = INDEX_W'(idx);
                        res.byte_offset = scaled(idx);
                    end
                end
            end else if (object_size == 0) begin
                res.status = ST_RANGE;
            end else begin
                quot = offset / object_size;
                if (quot >= n) begin
                    res.status = ST_RANGE;
                end else begin
                    idx = quot;
                    if (!usage_words[idx / WORD_BITS][idx % WORD_BITS]) begin
                        res.status = ST_NOTALLOC;
                    end else begin
                        usage_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
                        if (in_use != 0) in_use--;
                        res.status      = ST_OK;
                        res.index       = INDEX_W'(idx);
                        res.byte_offset = scaled(idx);
                    end
                end
            end
            res.used_count = COUNT_W'(in_use);
            awaited_outcomes.push_back(res);
        endfunction

        // Compare one delivered outcome against the oldest queued one.
        function void check_result(logic [1:0] status, logic [INDEX_W-1:0] index,
                                   logic [OFFSET_W-1:0] byte_offset,
                                   logic [COUNT_W-1:0] used_count);
            t_alloc_outcome want;
            if (awaited_outcomes.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: result with no request outstanding: st=%0d idx=%0d",
                             status, index);
                return;
            end
            want = awaited_outcomes.pop_front();
            if (want.status !== status || want.index !== index ||
                want.byte_offset !== byte_offset || want.used_count !== used_count) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: at %0t expected st=%0d idx=%0d off=0x%07h used=%0d, %s",
                             $realtime, want.status, want.index, want.byte_offset,
                             want.used_count,
                             $sformatf("got st=%0d idx=%0d off=0x%07h used=%0d",
                                       status, index, byte_offset, used_count));
            end
        endfunction

        // Find some object inside the pool that is currently allocated.
        function bit pick_in_use(output int unsigned idx);
            int unsigned n, start, k, probe;
            n   = pool_objects();
            idx = 0;
            if (n == 0) return 0;
            start = $urandom_range(0, n - 1);
            for (k = 0; k < n; k++) begin
                probe = (start + k) % n;
                if (usage_words[probe / WORD_BITS][probe % WORD_BITS]) begin
                    idx = probe;
                    return 1;
                end
            end
            return 0;
        endfunction
    endclass

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic               cfg_addr    = CFG_OBJ_SIZE;
    logic [SIZE_W-1:0]  cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata     = '0;   // [27:0] offset
    logic [0:0]         s_tuser     = '0;   // [0] opcode
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [55:0]        m_tdata;            // [11:0] index, [39:12] byte_offset,
                                            // [52:40] used_count
    logic [1:0]         m_tuser;            // [1:0] status

    // Idle control: hurry forces back-to-back traffic on both sides, the quiet
    // flags give each side its own stretches without gaps.
    bit hurry   = 1'b0;
    bit s_quiet = 1'b0;
    bit m_quiet = 1'b0;

    allocator_mirror board = new();

    bitmap_object_allocator_core #(
        .MAX_OBJECTS(POOL_MAX)
    ) u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wr_data(cfg_wr_data),
        .i_s_tvalid   (s_tvalid),
        .o_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .o_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .o_m_tdata    (m_tdata),
        .o_m_tuser    (m_tuser)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Byte offset that lands on object idx, with a random remainder inside the
    // object so rounding down gets exercised. Fall back to the bare product, or
    // to noise, when the result would not fit the offset field.
    function automatic logic [OFFSET_W-1:0] offset_of(int unsigned idx);
        longint unsigned size, base, off;
        size = board.object_size;
        base = idx * size;
        off  = base;
        if (size > 1) off = base + $urandom_range(0, int'(size) - 1);
        if (off > OFFSET_TOP) off = base;
        if (off > OFFSET_TOP) off = {$urandom} & OFFSET_TOP;
        return off[OFFSET_W-1:0];
    endfunction

    // Present one request, hold it until the transfer, then draw the gap
    // before the next one. Entered and left at a falling edge.
    task automatic send_request(logic op, logic [OFFSET_W-1:0] offset);
        int unsigned gap;
        s_tdata  <= {{(32 - OFFSET_W){1'b0}}, offset};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (s_tready !== 1'b1);
        board.note_request(op, offset);
        @(negedge clk);
        if ($urandom_range(0, 39) == 0) s_quiet = ($urandom_range(0, 2) == 0);
        gap = (hurry || s_quiet) ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Mostly allocations and frees of live objects; the rest are frees of
    // arbitrary objects, frees just past the pool end and raw noise.
    task automatic send_random();
        int unsigned         roll, n, idx;
        bit                  found;
        logic [OFFSET_W-1:0] noise;
        roll  = $urandom_range(0, 99);
        n     = board.pool_objects();
        noise = OFFSET_W'($urandom);
        found = board.pick_in_use(idx);
        if (roll < 50) begin
            send_request(OP_ALLOC, noise);
        end else if (roll < 80 && found) begin
            send_request(OP_FREE, offset_of(idx));
        end else if (roll < 90) begin
            if ($urandom_range(0, 1) == 0 && n != 0) idx = $urandom_range(0, n - 1);
            else idx = $urandom_range(0, POOL_MAX - 1);
            send_request(OP_FREE, offset_of(idx));
        end else if (roll < 95) begin
            send_request(OP_FREE, offset_of(n));
        end else begin
            send_request(OP_FREE, noise);
        end
    endtask

    // Drop valid, wait for every outcome, then give the block time to go idle.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.awaited_outcomes.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic addr, logic [SIZE_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        board.write_register(addr, value);
        @(negedge clk);
    endtask

    task automatic run_phase(logic [SIZE_W-1:0] size, logic [SIZE_W-1:0] count,
                             int unsigned items);
        settle();
        write_register(CFG_OBJ_SIZE, size);
        write_register(CFG_OBJ_COUNT, count);
        repeat (items) send_random();
    endtask

    // Reset values: 64-byte objects, full 4096-object pool.
    task automatic run_directed();
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, OFFSET_TOP);       // offset is don't-care on allocate
        send_request(OP_ALLOC, 28'h5A5A5A5);
        send_request(OP_FREE, 28'd64);            // object 1
        send_request(OP_FREE, 28'd64);            // object 1 again, already free
        send_request(OP_FREE, 28'd191);           // rounds down to object 2
        send_request(OP_ALLOC, '0);               // lowest hole is object 1
        send_request(OP_FREE, 28'd262144);        // first byte past the pool
        send_request(OP_FREE, OFFSET_TOP);
        send_request(OP_FREE, 28'd262143);        // last object, never allocated
        send_request(OP_FREE, '0);
        send_request(OP_ALLOC, '0);
    endtask

    // Result side: draw a stall per outcome, then take the next transfer.
    initial begin : result_sink
        int unsigned stall;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0) m_quiet = ($urandom_range(0, 2) == 0);
            stall = (hurry || m_quiet) ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            board.check_result(m_tuser, m_tdata[11:0], m_tdata[39:12], m_tdata[52:40]);
            @(negedge clk);
        end
    end

    initial begin : stimulus
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_phase(17'd1, 17'd1, 30);          // single-object pool, byte-sized objects
        run_phase(17'd3, 17'd70, 200);        // pool ends inside the second word
        run_phase(17'd0, 17'd100, 50);        // zero object size
        run_phase(17'd100, 17'd0, 30);        // empty pool
        run_phase(17'd5, 17'd130, 200);
        run_phase(17'd65536, 17'd4096, 150);  // top bit of the size register

        // Largest size, count past capacity: fill several hundred objects so
        // scans cross many words.
        settle();
        write_register(CFG_OBJ_SIZE, 17'd131071);
        write_register(CFG_OBJ_COUNT, 17'd8191);
        hurry = 1'b1;
        while (board.in_use < 700) send_request(OP_ALLOC, OFFSET_W'($urandom));
        hurry = 1'b0;
        repeat (100) send_random();

        run_phase(17'd7, 17'd40, 120);        // shrink below the live objects
        run_phase(17'd1, 17'd4096, 150);      // grow again, free the stragglers
        run_phase(SIZE_RESET, COUNT_RESET, 150);

        settle();
        if (board.failures == 0 && board.awaited_outcomes.size() == 0) begin
            $display("bitmap_object_allocator_core test passed");
        end else begin
            $display("bitmap_object_allocator_core test failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #20_000_000;
        $display("bitmap_object_allocator_core test failed");
        $finish;
    end

endmodule
